/* sv/lpr_pkg.sv */
// lpr_pkg: shared widths, codes and the per-channel residual function
// of the lossless predictor residual block
// no dependencies
package lpr_pkg;

    localparam int unsigned PIX_W             = 8;
    localparam int unsigned RGB_W             = 3 * PIX_W;
    localparam int unsigned DEF_MAX_ROW_WIDTH = 4096;
    localparam int unsigned PSEL_W            = 4;
    localparam int unsigned RWID_W            = 13;
    localparam int unsigned CFG_IDX_W         = 1;
    localparam int unsigned CFG_DATA_W        = 13;
    localparam logic [RWID_W-1:0] RWID_RESET  = 13'd4096;

    typedef logic [PIX_W-1:0] t_chan;

    // predictor codes
    typedef enum logic [PSEL_W-1:0] {
        PRED_NONE     = 4'd0,
        PRED_W        = 4'd1,
        PRED_N        = 4'd2,
        PRED_NW       = 4'd3,
        PRED_GRAD     = 4'd4,
        PRED_N_HALF   = 4'd5,
        PRED_W_HALF   = 4'd6,
        PRED_AVG      = 4'd7,
        PRED_MED      = 4'd8
    } t_pred_sel;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRED_SEL  = 1'b0,
        REG_ROW_WIDTH = 1'b1
    } t_cfg_reg;

    // x minus prediction, modulo 256; halving truncates toward zero
    function automatic t_chan residual(t_chan x, t_chan w, t_chan n, t_chan nw,
                                       t_pred_sel sel);
        logic signed [PIX_W+1:0] sw;
        logic signed [PIX_W+1:0] sn;
        logic signed [PIX_W+1:0] snw;
        logic signed [PIX_W+1:0] grad;
        logic signed [PIX_W+1:0] d_w;
        logic signed [PIX_W+1:0] d_n;
        logic signed [PIX_W+1:0] half_w;
        logic signed [PIX_W+1:0] half_n;
        logic signed [PIX_W+1:0] avg;
        logic signed [PIX_W+1:0] p;
        t_chan lo;
        t_chan hi;
        sw     = signed'({2'b00, w});
        sn     = signed'({2'b00, n});
        snw    = signed'({2'b00, nw});
        grad   = sw + sn - snw;
        d_w    = sw - snw;
        d_n    = sn - snw;
        half_w = (d_w + signed'({{(PIX_W+1){1'b0}}, d_w[PIX_W+1]})) >>> 1;
        half_n = (d_n + signed'({{(PIX_W+1){1'b0}}, d_n[PIX_W+1]})) >>> 1;
        avg    = (sw + sn) >>> 1;
        lo     = (w < n) ? w : n;
        hi     = (w < n) ? n : w;
        case (sel)
            PRED_W:      p = sw;
            PRED_N:      p = sn;
            PRED_NW:     p = snw;
            PRED_GRAD:   p = grad;
            PRED_N_HALF: p = sn + half_w;
            PRED_W_HALF: p = sw + half_n;
            PRED_AVG:    p = avg;
            PRED_MED: begin
                if (nw >= hi) begin
                    p = signed'({2'b00, lo});
                end else if (nw <= lo) begin
                    p = signed'({2'b00, hi});
                end else begin
                    p = grad;
                end
            end
            default:     p = '0;
        endcase
        return x - p[PIX_W-1:0];
    endfunction

endpackage

/* sv/lpr_pix_if.sv */
// lpr_pix_if: valid/ready channel carrying one rgb pixel item
// depends on lpr_pkg
interface lpr_pix_if import lpr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_chan pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;
    logic  frame_start;

    modport source (output valid, pixel_red, pixel_green, pixel_blue, frame_start,
                    input ready);
    modport sink   (input valid, pixel_red, pixel_green, pixel_blue, frame_start,
                    output ready);
endinterface

/* sv/lpr_res_if.sv */
// lpr_res_if: valid/ready channel carrying one residual item
// depends on lpr_pkg
interface lpr_res_if import lpr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_chan residual_red;
    logic [PIX_W-1:0] residual_green;
    logic [PIX_W-1:0] residual_blue;

    modport source (output valid, residual_red, residual_green, residual_blue,
                    input ready);
    modport sink   (input valid, residual_red, residual_green, residual_blue,
                    output ready);
endinterface

/* sv/lossless_predictor_residual.sv */
// lossless_predictor_residual: rgb predictor residual generator with line memory
// depends on lpr_pkg, lpr_pix_if, lpr_res_if
//
// Usage:
//   i_pix carries rgb pixels in raster order; frame_start marks the first pixel
//   of an image. o_res returns one residual item per pixel, in order: each
//   channel minus its prediction from W, N and NW, modulo 256.
//   Configuration (predictor select, row width) is written through i_cfg_we,
//   i_cfg_index and i_cfg_data while no item is in flight.
//   An accepted item is registered in stage 1 and then in the output register,
//   from which o_res takes it. Throughput: one item per cycle while o_res
//   does not stall. The line memory does one read-first access per item (read
//   N, write the pixel at the same column) in the accept cycle; stage 1 forms
//   the predictions and loads the output register.
//   Reset clears the column counter, the first-row flag, the pipeline valids
//   and config registers; the line memory is not cleared, since the first row of
//   an image never reads it. The first pixel after reset acts as a frame start.
//   When o_res stalls, the result holds in the output register and stage 1
//   still takes one more item; i_pix.ready drops only when both are full.
module lossless_predictor_residual import lpr_pkg::*; #(
    parameter int unsigned MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lpr_pix_if.sink               i_pix,
    lpr_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned COL_W = $clog2(MAX_ROW_WIDTH);
    localparam int unsigned CNT_W = COL_W + 1;
    localparam int unsigned CMP_W = (CNT_W > RWID_W) ? CNT_W : RWID_W;

    // configuration registers
    t_pred_sel          r_pred_sel;
    logic [RWID_W-1:0]  r_row_width;

    // row position state
    logic [COL_W-1:0]   r_col;
    logic               r_first_row;
    logic [RGB_W-1:0]   r_left;

    // line memory and its read register
    logic [RGB_W-1:0]   r_line_mem [MAX_ROW_WIDTH];
    logic [RGB_W-1:0]   r_line_rd;

    // stage 1
    logic               r_s1_valid;
    logic [RGB_W-1:0]   r_s1_x;
    logic [RGB_W-1:0]   r_s1_w;
    logic               r_s1_first;
    logic               r_s1_col0;
    logic [RGB_W-1:0]   r_prev_n;

    // output register
    logic               r_out_valid;
    t_chan              r_res_red;
    t_chan              r_res_green;
    t_chan              r_res_blue;

    logic               accept;
    logic               s1_adv;
    logic [CMP_W-1:0]   eff_width;
    logic [CMP_W-1:0]   rw_ext;
    logic [CMP_W-1:0]   max_ext;
    logic               stale_col;
    logic [COL_W-1:0]   cur_col;
    logic               cur_first;
    logic [CNT_W-1:0]   col_next;
    logic               row_wrap;
    logic [RGB_W-1:0]   in_x;
    logic [RGB_W-1:0]   s1_n;
    logic [RGB_W-1:0]   s1_nw;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred_sel  <= PRED_NONE;
            r_row_width <= RWID_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_PRED_SEL:  r_pred_sel  <= t_pred_sel'(i_cfg_data[PSEL_W-1:0]);
                REG_ROW_WIDTH: r_row_width <= i_cfg_data[RWID_W-1:0];
                default: ;
            endcase
        end
    end

    // handshakes
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign accept      = i_pix.valid && i_pix.ready;

    // effective row width: zero acts as one, clamp to the memory depth
    assign rw_ext    = CMP_W'(r_row_width);
    assign max_ext   = CMP_W'(MAX_ROW_WIDTH);
    assign eff_width = (rw_ext == '0) ? CMP_W'(1) : ((rw_ext > max_ext) ? max_ext : rw_ext);

    // column of the incoming item; a lowered width starts a new row first
    assign stale_col = CMP_W'(r_col) >= eff_width;
    assign cur_col   = (i_pix.frame_start || stale_col) ? '0 : r_col;
    assign cur_first = i_pix.frame_start ? 1'b1 : (stale_col ? 1'b0 : r_first_row);
    assign col_next  = CNT_W'(cur_col) + CNT_W'(1);
    assign row_wrap  = CMP_W'(col_next) >= eff_width;
    assign in_x      = {i_pix.pixel_red, i_pix.pixel_green, i_pix.pixel_blue};

    // row position update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
        end else if (accept) begin
            r_col       <= row_wrap ? '0 : col_next[COL_W-1:0];
            r_first_row <= row_wrap ? 1'b0 : cur_first;
        end
    end

    // left pixel and stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left     <= in_x;
            r_s1_x     <= in_x;
            r_s1_w     <= (cur_col == '0) ? '0 : r_left;
            r_s1_first <= cur_first;
            r_s1_col0  <= (cur_col == '0);
        end
    end

    // line memory: read-first access at the item's column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line_rd         <= r_line_mem[cur_col];
            r_line_mem[cur_col] <= in_x;
        end
    end

    // stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // neighbors above; NW is the N of the previous item
    assign s1_n  = r_s1_first ? '0 : r_line_rd;
    assign s1_nw = (r_s1_first || r_s1_col0) ? '0 : r_prev_n;

    // predictions and output register load
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_prev_n    <= s1_n;
            r_res_red   <= residual(r_s1_x[23:16], r_s1_w[23:16], s1_n[23:16],
                                    s1_nw[23:16], r_pred_sel);
            r_res_green <= residual(r_s1_x[15:8], r_s1_w[15:8], s1_n[15:8],
                                    s1_nw[15:8], r_pred_sel);
            r_res_blue  <= residual(r_s1_x[7:0], r_s1_w[7:0], s1_n[7:0],
                                    s1_nw[7:0], r_pred_sel);
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.residual_red   = r_res_red;
    assign o_res.residual_green = r_res_green;
    assign o_res.residual_blue  = r_res_blue;

    // an accepted item always lands in stage 1
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted item missing from stage 1");

    // a frame start clears all neighbors of its item
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_pix.frame_start |=> r_s1_first && r_s1_col0 && (r_s1_w == '0))
        else $error("frame start item carries neighbors");

    // a stage 1 item that cannot advance is kept
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_x))
        else $error("stalled stage 1 item lost");

endmodule

/* test/tb_lossless_predictor_residual.sv */
// tb_lossless_predictor_residual: self-checking bench for the rgb predictor residual block
// depends on lpr_pkg, lpr_pix_if, lpr_res_if and lossless_predictor_residual
// random idling on both channels, one long output stall, residuals checked per channel
module tb_lossless_predictor_residual import lpr_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_ROW      = DEF_MAX_ROW_WIDTH;
    localparam int unsigned MAX_IDLE     = 17;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam logic [PSEL_W-1:0] PSEL_UNUSED_LO = 4'd9;
    localparam logic [PSEL_W-1:0] PSEL_UNUSED_HI = 4'd15;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        logic  frame_start;
    } t_pixel;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_residual;

    // line memory, neighbor registers and expected residual items
    class residual_scoreboard;
        logic [RGB_W-1:0]  line_store [MAX_ROW];
        bit                line_written [MAX_ROW];
        int unsigned       column;
        bit                first_row;
        logic [RGB_W-1:0]  west_pix;
        logic [RGB_W-1:0]  north_west_pix;
        logic [PSEL_W-1:0] pred_sel;
        logic [RWID_W-1:0] row_width;
        t_residual         expected_q[$];
        int unsigned       mismatches;
        int unsigned       checked;

        function new();
            foreach (line_written[i]) line_written[i] = 1'b0;
            column         = 0;
            first_row      = 1'b1;
            west_pix       = '0;
            north_west_pix = '0;
            pred_sel       = PRED_NONE;
            row_width      = RWID_RESET;
            mismatches     = 0;
            checked        = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PRED_SEL:  pred_sel  = data[PSEL_W-1:0];
                REG_ROW_WIDTH: row_width = data[RWID_W-1:0];
                default: ;
            endcase
        endfunction

        // zero acts as one, oversize values clamp to the line memory depth
        function int unsigned active_width();
            if (row_width == 0) return 1;
            if (row_width > MAX_ROW) return MAX_ROW;
            return row_width;
        endfunction

        function void begin_row();
            column         = 0;
            first_row      = 1'b0;
            west_pix       = '0;
            north_west_pix = '0;
        endfunction

        function t_chan chan_residual(t_chan x, t_chan w, t_chan n, t_chan nw);
            int iw;
            int in_;
            int inw;
            int lo;
            int hi;
            int p;
            iw  = int'(w);
            in_ = int'(n);
            inw = int'(nw);
            lo  = (iw < in_) ? iw : in_;
            hi  = (iw < in_) ? in_ : iw;
            case (pred_sel)
                PRED_W:      p = iw;
                PRED_N:      p = in_;
                PRED_NW:     p = inw;
                PRED_GRAD:   p = iw + in_ - inw;
                PRED_N_HALF: p = in_ + (iw - inw) / 2;
                PRED_W_HALF: p = iw + (in_ - inw) / 2;
                PRED_AVG:    p = (iw + in_) / 2;
                PRED_MED: begin
                    if (inw >= hi) p = lo;
                    else if (inw <= lo) p = hi;
                    else p = iw + in_ - inw;
                end
                default:     p = 0;
            endcase
            return t_chan'(int'(x) - p);
        endfunction

        // true when this item would read a line entry never written since reset
        function bit would_read_unwritten(bit frame_start);
            int unsigned c;
            bit          top;
            if (frame_start) return 1'b0;
            c   = column;
            top = first_row;
            if (c >= active_width()) begin
                c   = 0;
                top = 1'b0;
            end
            if (c >= MAX_ROW) c = 0;
            return !top && !line_written[c];
        endfunction

        // accepted pixel: form the expected residual and advance the raster position
        function void note_pixel(t_pixel px);
            logic [RGB_W-1:0] x;
            logic [RGB_W-1:0] w;
            logic [RGB_W-1:0] n;
            logic [RGB_W-1:0] nw;
            logic [RGB_W-1:0] r;
            int unsigned      c;
            x = {px.red, px.green, px.blue};
            if (px.frame_start) begin
                column         = 0;
                first_row      = 1'b1;
                west_pix       = '0;
                north_west_pix = '0;
            end else if (column >= active_width()) begin
                begin_row();
            end
            c  = (column >= MAX_ROW) ? 0 : column;
            w  = (c == 0) ? '0 : west_pix;
            n  = first_row ? '0 : line_store[c];
            nw = (first_row || c == 0) ? '0 : north_west_pix;
            for (int sh = 0; sh < RGB_W; sh += PIX_W) begin
                r[sh +: PIX_W] = chan_residual(x[sh +: PIX_W], w[sh +: PIX_W],
                                               n[sh +: PIX_W], nw[sh +: PIX_W]);
            end
            expected_q.insert(expected_q.size(), t_residual'(r));
            north_west_pix  = n;
            line_store[c]   = x;
            line_written[c] = 1'b1;
            west_pix        = x;
            column          = c + 1;
            if (column >= active_width()) begin_row();
        endfunction

        function void check_residual(t_residual got);
            t_residual exp;
            checked++;
            if (expected_q.size() == 0) begin
                $error("residual item with no pixel pending: %h", got);
                mismatches++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.red !== exp.red) begin
                $error("residual_red: expected %0d, actual %0d", exp.red, got.red);
                mismatches++;
            end
            if (got.green !== exp.green) begin
                $error("residual_green: expected %0d, actual %0d", exp.green, got.green);
                mismatches++;
            end
            if (got.blue !== exp.blue) begin
                $error("residual_blue: expected %0d, actual %0d", exp.blue, got.blue);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lpr_pix_if pix ();
    lpr_res_if res ();

    residual_scoreboard sb;
    int unsigned        cycles;
    int unsigned        pixels_sent;
    int unsigned        frame_starts;
    int unsigned        settings;
    int unsigned        hold_cycles;
    bit                 rcv_stalls;
    t_pixel             last_px;

    lossless_predictor_residual dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pix       (pix),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, one long hold on request
    initial begin
        int unsigned stall;
        t_residual   got;
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = 0;
            if (hold_cycles != 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else if (rcv_stalls) begin
                stall = $urandom_range(0, MAX_IDLE);
            end
            if (stall != 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!(res.valid && res.ready));
            got.red   = res.residual_red;
            got.green = res.residual_green;
            got.blue  = res.residual_blue;
            sb.check_residual(got);
        end
    end

    task automatic wait_drain();
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // offer one pixel after an optional gap and hold it until taken
    task automatic send_pixel(t_pixel px, int unsigned gap);
        if (gap != 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.pixel_red   <= px.red;
        pix.pixel_green <= px.green;
        pix.pixel_blue  <= px.blue;
        pix.frame_start <= px.frame_start;
        do @(posedge clk); while (!(pix.valid && pix.ready));
        sb.note_pixel(px);
        pixels_sent++;
        if (px.frame_start) frame_starts++;
        last_px = px;
    endtask

    // both registers, written only once the block has emptied
    task automatic set_config(logic [PSEL_W-1:0] sel, logic [RWID_W-1:0] width);
        pix.valid <= 1'b0;
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_PRED_SEL;
        cfg_data  <= CFG_DATA_W'(sel);
        @(posedge clk);
        sb.write_reg(REG_PRED_SEL, CFG_DATA_W'(sel));
        cfg_index <= REG_ROW_WIDTH;
        cfg_data  <= CFG_DATA_W'(width);
        @(posedge clk);
        sb.write_reg(REG_ROW_WIDTH, CFG_DATA_W'(width));
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic t_pixel mk_pixel(t_chan r, t_chan g, t_chan b, logic fs);
        t_pixel px;
        px.red         = r;
        px.green       = g;
        px.blue        = b;
        px.frame_start = fs;
        return px;
    endfunction

    // mostly smooth image content, with full-range noise and extremes mixed in
    function automatic t_chan rand_chan(t_chan prev);
        case ($urandom_range(0, 3))
            0: return t_chan'($urandom_range(0, 255));
            1: begin
                case ($urandom_range(0, 3))
                    0: return 8'd0;
                    1: return 8'd255;
                    2: return 8'd128;
                    default: return 8'd127;
                endcase
            end
            default: return prev + t_chan'($urandom_range(0, 14)) - 8'd7;
        endcase
    endfunction

    task automatic run_phase(int unsigned count, bit send_stalls);
        t_pixel      px;
        int unsigned gap;
        for (int unsigned i = 0; i < count; i++) begin
            px.red         = rand_chan(last_px.red);
            px.green       = rand_chan(last_px.green);
            px.blue        = rand_chan(last_px.blue);
            px.frame_start = (i == 0 && $urandom_range(0, 1) == 0)
                             || $urandom_range(0, 49) == 0;
            // a row widened past what was ever stored must begin a new image
            if (sb.would_read_unwritten(px.frame_start)) px.frame_start = 1'b1;
            gap = send_stalls ? $urandom_range(0, MAX_IDLE) : 0;
            send_pixel(px, gap);
        end
        pix.valid <= 1'b0;
        wait_drain();
    endtask

    initial begin
        t_pred_sel         ops [6];
        logic [PSEL_W-1:0] sel;
        logic [RWID_W-1:0] width;
        int unsigned       phase;
        int unsigned       count;
        int unsigned       mode;
        int unsigned       target;
        sb              = new();
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_PRED_SEL;
        cfg_data        = '0;
        pix.valid       = 1'b0;
        pix.pixel_red   = '0;
        pix.pixel_green = '0;
        pix.pixel_blue  = '0;
        pix.frame_start = 1'b0;
        cycles          = 0;
        pixels_sent     = 0;
        frame_starts    = 0;
        settings        = 0;
        hold_cycles     = 0;
        rcv_stalls      = 1'b0;
        last_px         = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: first pixel without frame start still opens an image
        send_pixel(mk_pixel(8'd255, 8'd0, 8'd170, 1'b0), 0);
        send_pixel(mk_pixel(8'd0, 8'd255, 8'd85, 1'b0), 0);

        // gradient on three-pixel rows, then a frame start in the middle of a row
        set_config(PRED_GRAD, 13'd3);
        send_pixel(mk_pixel(8'd255, 8'd255, 8'd255, 1'b0), 0);
        send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 1'b0), 0);
        send_pixel(mk_pixel(8'd255, 8'd255, 8'd255, 1'b0), 0);
        send_pixel(mk_pixel(8'd128, 8'd127, 8'd1, 1'b0), 0);
        send_pixel(mk_pixel(8'd255, 8'd0, 8'd255, 1'b0), 0);
        send_pixel(mk_pixel(8'd17, 8'd34, 8'd51, 1'b1), 0);
        send_pixel(mk_pixel(8'd200, 8'd100, 8'd50, 1'b0), 0);

        // row narrowed below the current column: a new row starts first
        set_config(PRED_MED, 13'd2);
        send_pixel(mk_pixel(8'd0, 8'd255, 8'd128, 1'b0), 0);
        send_pixel(mk_pixel(8'd255, 8'd0, 8'd127, 1'b0), 0);
        send_pixel(mk_pixel(8'd255, 8'd255, 8'd0, 1'b0), 0);
        send_pixel(mk_pixel(8'd0, 8'd0, 8'd255, 1'b0), 0);

        // zero width acts as one, unused selector codes predict nothing
        set_config(PSEL_UNUSED_LO, 13'd0);
        send_pixel(mk_pixel(8'd1, 8'd2, 8'd4, 1'b0), 0);
        send_pixel(mk_pixel(8'd8, 8'd16, 8'd32, 1'b0), 0);
        send_pixel(mk_pixel(8'd64, 8'd128, 8'd254, 1'b0), 0);

        // oversize width clamps; stays on columns already stored
        set_config(PSEL_UNUSED_HI, 13'd8191);
        send_pixel(mk_pixel(8'd254, 8'd253, 8'd251, 1'b0), 0);
        send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 1'b0), 0);
        send_pixel(mk_pixel(8'd255, 8'd255, 8'd255, 1'b0), 0);

        // remaining predictors, one item each
        ops = '{PRED_W, PRED_N, PRED_NW, PRED_N_HALF, PRED_W_HALF, PRED_AVG};
        foreach (ops[i]) begin
            set_config(ops[i], 13'd2);
            send_pixel(mk_pixel(8'd255, 8'd0, 8'd129, 1'b0), 0);
        end

        // random phases: every predictor first, then any code and width
        target = pixels_sent + RANDOM_ITEMS;
        phase  = 0;
        while (pixels_sent < target) begin
            if (phase < 9) sel = PSEL_W'(phase);
            else if ($urandom_range(0, 7) == 0) sel = PSEL_W'($urandom_range(9, 15));
            else sel = PSEL_W'($urandom_range(0, 8));
            case ($urandom_range(0, 15))
                0: width = 13'd0;
                1: begin
                    case ($urandom_range(0, 2))
                        0: width = 13'd4096;
                        1: width = 13'd4097;
                        default: width = 13'd8191;
                    endcase
                end
                2, 3: width = RWID_W'($urandom_range(17, 300));
                default: width = RWID_W'($urandom_range(1, 16));
            endcase
            count = (width > 300) ? $urandom_range(30, 100) : $urandom_range(40, 120);
            set_config(sel, width);
            if (phase == 3) begin
                // long output hold while the input keeps offering
                hold_cycles = HOLD_CYCLES;
                rcv_stalls  = 1'b0;
                run_phase(count, 1'b0);
            end else begin
                mode       = $urandom_range(0, 3);
                rcv_stalls = mode[1];
                run_phase(count, mode[0]);
            end
            phase++;
        end

        pix.valid <= 1'b0;
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d pixel items over %0d register settings, %0d of them frame starts",
                 pixels_sent, settings, frame_starts);
        $display("%0d residual items checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
sv/lpr_pkg.sv
sv/lpr_pix_if.sv
sv/lpr_res_if.sv
sv/lossless_predictor_residual.sv
test/tb_lossless_predictor_residual.sv
